// ===== design/sfcc_pkg.sv =====
// sfcc_pkg: shared constants and crc helper for the sensor frame check block
`default_nettype none

package sfcc_pkg;

  // field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned WordW   = 16;
  localparam int unsigned TempW   = 15;
  localparam int unsigned HumW    = 14;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PosW    = 3;

  // crc-8 settings
  localparam logic [ByteW-1:0] CrcInit = 8'hFF;
  localparam logic [ByteW-1:0] CrcPoly = 8'h31;

  // scaling constants
  localparam logic [12:0] TempMul = 13'd4375;
  localparam logic [9:0]  HumMul  = 10'd625;
  localparam logic [TempW-1:0] TempOffset = 15'd4500;
  localparam int unsigned TempShift = 14;
  localparam int unsigned HumShift  = 12;

  // frame byte positions
  localparam logic [PosW-1:0] PosTempHi  = 3'd0;
  localparam logic [PosW-1:0] PosTempLo  = 3'd1;
  localparam logic [PosW-1:0] PosTempCrc = 3'd2;
  localparam logic [PosW-1:0] PosHumHi   = 3'd3;
  localparam logic [PosW-1:0] PosHumLo   = 3'd4;
  localparam logic [PosW-1:0] PosHumCrc  = 3'd5;

  // status bits
  localparam int unsigned StatTempBad = 0;
  localparam int unsigned StatHumBad  = 1;

  // one byte through crc-8, msb first
  function automatic logic [ByteW-1:0] crc8_feed(input logic [ByteW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
    logic [ByteW-1:0] c;
    c = crc ^ b;
    for (int i = 0; i < ByteW; i++) begin
      if (c[ByteW-1]) begin
        c = {c[ByteW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[ByteW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/sfcc_if.sv =====
// sfcc_if: valid/ready channels for frame bytes and scaled results
`default_nettype none

interface sfcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_start;

  modport source (output valid, output frame_byte, output frame_start, input ready);
  modport sink   (input valid, input frame_byte, input frame_start, output ready);
endinterface

interface sfcc_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] temperature_centi;
  logic        [13:0] humidity_centi;
  logic        [1:0]  check_status;

  modport source (output valid, output temperature_centi, output humidity_centi,
                  output check_status, input ready);
  modport sink   (input valid, input temperature_centi, input humidity_centi,
                  input check_status, output ready);
endinterface

`default_nettype wire

// ===== design/sensor_frame_crc_check_and_scale.sv =====
// Sensor frame check and scale: crc-8 check of two words, scaled result per frame
//
// Input channel in_i carries one byte of a six-byte frame per item: temperature
// high, low, crc, humidity high, low, crc. frame_start restarts the frame at the
// temperature high byte; without it, frames simply follow one another.
// Each word is checked with crc-8 (poly 0x31, init 0xff, msb first).
// On the sixth byte one result item goes out on out_o: temperature in hundredths
// of a degree, humidity in hundredths of a percent and a status with bit 0 for a
// bad temperature crc and bit 1 for a bad humidity crc. Values are sent even
// when a check fails. Other bytes give no result.
// Throughput: one byte per cycle unless a sixth byte waits on a stalled result.
// The result is valid the cycle after the sixth byte is accepted, from a register.
// When the receiver stalls, bytes that produce no result are still taken; only
// a sixth byte waits until the held result is taken.
// Reset clears the frame position, the crc and the output valid.
`default_nettype none

module sensor_frame_crc_check_and_scale (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sfcc_in_if.sink   in_i,
  sfcc_out_if.source out_o
);
  import sfcc_pkg::*;

  // frame state
  logic [PosW-1:0]  pos_q, pos_d;
  logic [ByteW-1:0] crc_q, crc_d;
  logic [ByteW-1:0] hi_q, hi_d;
  logic [WordW-1:0] temp_word_q, temp_word_d;
  logic [WordW-1:0] hum_word_q, hum_word_d;
  logic             temp_ok_q, temp_ok_d;

  // output register
  logic               out_valid_q;
  logic [TempW-1:0]   temp_q, temp_d;
  logic [HumW-1:0]    hum_q, hum_d;
  logic [StatusW-1:0] status_q, status_d;

  logic [PosW-1:0]  pos_eff;
  logic             emit;
  logic             in_fire;
  logic [28:0]      temp_prod;
  logic [25:0]      hum_prod;
  logic [TempW-1:0] temp_scaled;

  // effective position of the incoming byte
  assign pos_eff = in_i.frame_start ? PosTempHi : pos_q;
  assign emit    = (pos_eff == PosHumCrc);

  // take bytes unless a result would collide with a stalled one
  assign in_i.ready = !emit || !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  // scaling products
  assign temp_prod   = TempMul * temp_word_q;
  assign hum_prod    = HumMul * hum_word_q;
  assign temp_scaled = temp_prod[TempShift +: TempW];
  assign temp_d      = temp_scaled - TempOffset;
  assign hum_d       = hum_prod[HumShift +: HumW];

  // per-byte next state
  always_comb begin
    pos_d       = pos_q;
    crc_d       = crc_q;
    hi_d        = hi_q;
    temp_word_d = temp_word_q;
    hum_word_d  = hum_word_q;
    temp_ok_d   = temp_ok_q;
    status_d    = '0;
    unique case (pos_eff)
      PosTempLo: begin
        crc_d       = crc8_feed(crc_q, in_i.frame_byte);
        temp_word_d = {hi_q, in_i.frame_byte};
        pos_d       = PosTempCrc;
      end
      PosTempCrc: begin
        temp_ok_d = (crc_q == in_i.frame_byte);
        crc_d     = CrcInit;
        pos_d     = PosHumHi;
      end
      PosHumHi: begin
        crc_d = crc8_feed(CrcInit, in_i.frame_byte);
        hi_d  = in_i.frame_byte;
        pos_d = PosHumLo;
      end
      PosHumLo: begin
        crc_d      = crc8_feed(crc_q, in_i.frame_byte);
        hum_word_d = {hi_q, in_i.frame_byte};
        pos_d      = PosHumCrc;
      end
      PosHumCrc: begin
        status_d[StatTempBad] = !temp_ok_q;
        status_d[StatHumBad]  = (crc_q != in_i.frame_byte);
        crc_d = CrcInit;
        pos_d = PosTempHi;
      end
      default: begin
        crc_d = crc8_feed(CrcInit, in_i.frame_byte);
        hi_d  = in_i.frame_byte;
        pos_d = PosTempLo;
      end
    endcase
  end

  // frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= PosTempHi;
      crc_q       <= CrcInit;
      hi_q        <= '0;
      temp_word_q <= '0;
      hum_word_q  <= '0;
      temp_ok_q   <= 1'b0;
    end else if (in_fire) begin
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      hi_q        <= hi_d;
      temp_word_q <= temp_word_d;
      hum_word_q  <= hum_word_d;
      temp_ok_q   <= temp_ok_d;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      temp_q   <= temp_d;
      hum_q    <= hum_d;
      status_q <= status_d;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.temperature_centi = temp_q;
  assign out_o.humidity_centi    = hum_q;
  assign out_o.check_status      = status_q;

endmodule

`default_nettype wire
